[rtl/core/whhc_pkg.sv]
// ----------------------------------------------------------------------------
// whhc_pkg
// Types, widths and threshold tables for the water heater hysteresis control.
// ----------------------------------------------------------------------------
`default_nettype none

package whhc_pkg;

  localparam int unsigned TempW    = 12;
  localparam int unsigned WaitW    = 3;
  localparam int unsigned HoldW    = 9;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned AltW     = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  localparam logic [CfgIdxW-1:0] RegHeatingEnable = 1'd0;
  localparam logic [CfgIdxW-1:0] RegAltitudeLevel = 1'd1;

  localparam logic [LevelW-1:0] LevelLow = 2'd0;

  localparam logic signed [TempW-1:0] ProtectTemp = 12'sd980;

  typedef logic signed [TempW-1:0] temp_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic              sleep_saving;
    logic              unused_saving;
    logic              cleaning_active;
    logic              sterilizing;
    logic              hot_fault;
    logic              lock_all;
    logic              cover_open;
    logic [LevelW-1:0] room_level;
    logic              hot_tank_full;
    temp_t             water_temp;
  } in_beat_t;

  typedef struct packed {
    logic [4:0] pad;
    logic       heat_permitted;
    logic       holdoff_active;
    logic       heater_on;
  } out_beat_t;

  typedef struct packed {
    temp_t on_t;
    temp_t off_t;
  } thresh_t;

  function automatic thresh_t pick_thresh(input logic unused_sv, input logic sleep_sv,
                                          input logic [AltW-1:0] alt);
    thresh_t t;
    t.on_t  = 12'sd880;
    t.off_t = 12'sd930;
    if (unused_sv) begin
      t.on_t = 12'sd600;
      case (alt)
        2'd1:    t.off_t = 12'sd800;
        2'd2:    t.off_t = 12'sd760;
        default: t.off_t = 12'sd850;
      endcase
    end else if (sleep_sv) begin
      case (alt)
        2'd1:    begin t.on_t = 12'sd770; t.off_t = 12'sd880; end
        2'd2:    begin t.on_t = 12'sd770; t.off_t = 12'sd840; end
        default: begin t.on_t = 12'sd800; t.off_t = 12'sd930; end
      endcase
    end else begin
      case (alt)
        2'd1:    begin t.on_t = 12'sd830; t.off_t = 12'sd880; end
        2'd2:    begin t.on_t = 12'sd800; t.off_t = 12'sd840; end
        default: begin t.on_t = 12'sd880; t.off_t = 12'sd930; end
      endcase
    end
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/core/water_heater_hysteresis_control.sv]
// ----------------------------------------------------------------------------
// water_heater_hysteresis_control
// Per-tick heater decision: start-up wait, cover-open hold-off, permit checks
// and altitude-dependent hysteresis with a 98.0 C cut-off.
// ----------------------------------------------------------------------------
// One input beat is one one-second tick; each tick yields exactly one output
// beat. A beat is captured in an input register and evaluated into the output
// register once that register is free, and a new tick is taken every cycle
// while the output side keeps up. The input register frees as soon as its
// beat moves to the output register, so a waiting result does not block the
// next tick from entering. Temperatures are signed tenths of a degree C.
// Write the configuration registers only while no tick is in flight.
`default_nettype none

module water_heater_hysteresis_control #(
  parameter int unsigned STARTUP_TICKS = 5,
  parameter int unsigned HOLDOFF_TICKS = 300
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [whhc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [whhc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // water_temp[11:0], hot_tank_full, room_level[1:0], cover_open, lock_all,
  // hot_fault, sterilizing, cleaning_active, unused_saving, sleep_saving, zero pad
  input  wire logic [whhc_pkg::InDataW-1:0]      s_axis_tdata,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // heater_on, holdoff_active, heat_permitted, zero pad
  output      logic [whhc_pkg::OutDataW-1:0]     m_axis_tdata
);
  import whhc_pkg::*;

  localparam logic [WaitW-1:0] StartupInit = WaitW'(STARTUP_TICKS);
  localparam logic [HoldW-1:0] HoldoffInit = HoldW'(HOLDOFF_TICKS);

  logic                 heat_en_q;
  logic [AltW-1:0]      alt_q;
  logic                 in_valid_q;
  in_beat_t             in_q;
  logic                 out_valid_q;
  out_beat_t            out_q, out_d;
  logic [WaitW-1:0]     wait_q, wait_d;
  logic [HoldW-1:0]     hold_q, hold_d;
  logic [LevelW-1:0]    prev_lvl_q;
  logic                 heater_q, heater_d;
  logic                 advance;
  logic                 in_take;
  logic [AltW-1:0]      alt_eff;
  logic [HoldW-1:0]     hold_cur;
  logic                 permit;
  thresh_t              thr;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign alt_eff = (alt_q == 2'd3) ? 2'd0 : alt_q;
  assign thr     = pick_thresh(in_q.unused_saving, in_q.sleep_saving, alt_eff);

  always_comb begin
    wait_d   = (wait_q != '0) ? wait_q - 1'b1 : wait_q;
    hold_cur = (in_q.cover_open && prev_lvl_q == LevelLow && in_q.room_level != LevelLow)
               ? HoldoffInit : hold_q;
    hold_d   = hold_cur;
    heater_d = heater_q;
    permit   = 1'b0;
    out_d    = '0;
    if (hold_cur != '0) begin
      hold_d   = hold_cur - 1'b1;
      heater_d = 1'b0;
      out_d.holdoff_active = 1'b1;
    end else begin
      permit = (wait_d == '0) && heat_en_q && in_q.hot_tank_full && !in_q.lock_all &&
               !in_q.hot_fault && !in_q.sterilizing && !in_q.cleaning_active;
      if (!permit) begin
        heater_d = 1'b0;
      end else begin
        if (heater_q) begin
          if (in_q.water_temp >= thr.off_t) heater_d = 1'b0;
        end else begin
          if (in_q.water_temp <= thr.on_t) heater_d = 1'b1;
        end
        if (in_q.water_temp >= ProtectTemp) heater_d = 1'b0;
      end
    end
    out_d.heat_permitted = permit;
    out_d.heater_on      = heater_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_en_q <= 1'b1;
      alt_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHeatingEnable: heat_en_q <= cfg_data_i[0];
        RegAltitudeLevel: alt_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wait_q      <= StartupInit;
      hold_q      <= '0;
      prev_lvl_q  <= LevelLow;
      heater_q    <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        wait_q      <= wait_d;
        hold_q      <= hold_d;
        prev_lvl_q  <= in_q.room_level;
        heater_q    <= heater_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_q  <= s_axis_tdata;
    if (advance) out_q <= out_d;
  end

`ifndef SYNTH
  a_hold_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.holdoff_active |-> !out_q.heater_on && !out_q.heat_permitted)
    else $error("hold-off beat shows heater on or permit");

  a_out_matches_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.heater_on == heater_q)
    else $error("output heater bit differs from heater state");

  a_heater_only_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(heater_q) && $stable(hold_q) && $stable(wait_q))
    else $error("state moved without a tick");

  a_wait_never_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> wait_q <= $past(wait_q))
    else $error("start-up wait increased");
`endif

endmodule

`default_nettype wire

[tb/water_heater_hysteresis_control_tb.sv]
// ----------------------------------------------------------------------------
// water_heater_hysteresis_control_tb
// Self-checking bench for the per-tick heater decision.
// ----------------------------------------------------------------------------
// A directed table covers the start-up wait, the temperature extremes, every
// blocking beat flag, the three threshold sets and the cover-open hold-off.
// It is followed by random phases that step through a mix of enable and
// altitude settings. Each output beat is checked against its listed result
// for typed rows and otherwise against a tick-level model of the control.
// Both sides idle at random but for two phases; the receiver holds off once
// for a long stretch, and the sender drains all results between phases.
`timescale 1ns / 1ps

module water_heater_hysteresis_control_tb;
  import whhc_pkg::*;

  localparam int unsigned StartupTicks = 5;
  localparam int unsigned HoldoffTicks = 300;
  localparam int unsigned PhaseBeats   = 145;
  localparam int unsigned LongPark     = 200;
  localparam int unsigned IdleLimit    = 5000;
  localparam logic [AltW-1:0] AltFallback = 2'd3;

  typedef enum logic [1:0] {TblUnused, TblSleep, TblNormal} limit_set_e;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t res;
  } tick_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  // tick model state and register copies
  logic [WaitW-1:0]  wait_cnt;
  logic [HoldW-1:0]  hold_cnt;
  logic [LevelW-1:0] last_level;
  logic              heating;
  logic              cfg_en;
  logic [AltW-1:0]   cfg_alt;

  out_beat_t pending_cmds[$];
  tick_row_t tick_rows[$];
  int        n_errors;
  int        n_cmds_checked;
  int        idle_cycles;
  int        park_cnt;
  bit        long_park_done;
  bit        no_idle;

  water_heater_hysteresis_control #(
    .STARTUP_TICKS(StartupTicks),
    .HOLDOFF_TICKS(HoldoffTicks)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void heat_limits(input in_beat_t b, output temp_t on_l,
                                      output temp_t off_l);
    limit_set_e       set;
    logic [AltW-1:0]  row;
    if (b.unused_saving) set = TblUnused;
    else if (b.sleep_saving) set = TblSleep;
    else set = TblNormal;
    row = (cfg_alt == AltFallback) ? 2'd0 : cfg_alt;
    case ({set, row})
      {TblUnused, 2'd0}: begin on_l = 12'sd600; off_l = 12'sd850; end
      {TblUnused, 2'd1}: begin on_l = 12'sd600; off_l = 12'sd800; end
      {TblUnused, 2'd2}: begin on_l = 12'sd600; off_l = 12'sd760; end
      {TblSleep, 2'd0}:  begin on_l = 12'sd800; off_l = 12'sd930; end
      {TblSleep, 2'd1}:  begin on_l = 12'sd770; off_l = 12'sd880; end
      {TblSleep, 2'd2}:  begin on_l = 12'sd770; off_l = 12'sd840; end
      {TblNormal, 2'd1}: begin on_l = 12'sd830; off_l = 12'sd880; end
      {TblNormal, 2'd2}: begin on_l = 12'sd800; off_l = 12'sd840; end
      default:           begin on_l = 12'sd880; off_l = 12'sd930; end
    endcase
  endfunction

  function automatic out_beat_t predict_heater(input in_beat_t b);
    out_beat_t r;
    temp_t     on_l;
    temp_t     off_l;
    logic      permit;
    r = '0;
    if (wait_cnt != '0) wait_cnt = wait_cnt - 1'b1;
    if (b.room_level != last_level) begin
      if (b.cover_open && last_level == LevelLow && b.room_level != LevelLow)
        hold_cnt = HoldW'(HoldoffTicks);
      last_level = b.room_level;
    end
    heat_limits(b, on_l, off_l);
    if (hold_cnt != '0) begin
      hold_cnt = hold_cnt - 1'b1;
      heating = 1'b0;
      r.holdoff_active = 1'b1;
    end else begin
      permit = (wait_cnt == '0) && cfg_en && b.hot_tank_full && !b.lock_all &&
               !b.hot_fault && !b.sterilizing && !b.cleaning_active;
      r.heat_permitted = permit;
      if (!permit) begin
        heating = 1'b0;
      end else begin
        if (heating) begin
          if (b.water_temp >= off_l) heating = 1'b0;
        end else if (b.water_temp <= on_l) begin
          heating = 1'b1;
        end
        if (b.water_temp >= ProtectTemp) heating = 1'b0;
      end
    end
    r.heater_on = heating;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic in_beat_t ok_beat(input int t);
    in_beat_t b;
    b = '0;
    b.water_temp = t[TempW-1:0];
    b.hot_tank_full = 1'b1;
    return b;
  endfunction

  function automatic out_beat_t cmd(input logic h, input logic ho, input logic p);
    out_beat_t r;
    r = '0;
    r.heater_on = h;
    r.holdoff_active = ho;
    r.heat_permitted = p;
    return r;
  endfunction

  task automatic add_row(input in_beat_t b, input bit typed, input out_beat_t r);
    tick_row_t row;
    row.beat = b;
    row.typed = typed;
    row.res = r;
    tick_rows.push_back(row);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    if (idx == RegHeatingEnable) cfg_en = val[0];
    else if (idx == RegAltitudeLevel) cfg_alt = val[AltW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_tick(input in_beat_t b, input bit typed, input out_beat_t r);
    out_beat_t p;
    int        gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    do @(posedge clk_i); while (!s_axis_tready);
    p = predict_heater(b);
    pending_cmds.push_back(typed ? r : p);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
  endtask

  // receiver side: random back-pressure plus one long hold
  initial begin
    int g;
    m_axis_tready = 1'b0;
    park_cnt = 0;
    long_park_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (park_cnt != 0) begin
        m_axis_tready = 1'b0;
        park_cnt--;
      end else if (!long_park_done && n_cmds_checked >= 200) begin
        long_park_done = 1'b1;
        m_axis_tready = 1'b0;
        park_cnt = LongPark - 1;
      end else begin
        g = pick_gap();
        m_axis_tready = (g == 0);
        if (g != 0) park_cnt = g - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = out_beat_t'(m_axis_tdata);
      if (pending_cmds.size() == 0) begin
        $error("unexpected output beat %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = pending_cmds.pop_front();
        n_cmds_checked++;
        if (got.heater_on !== want.heater_on) begin
          $error("heater_on: expected %0b, got %0b", want.heater_on, got.heater_on);
          n_errors++;
        end
        if (got.holdoff_active !== want.holdoff_active) begin
          $error("holdoff_active: expected %0b, got %0b", want.holdoff_active,
                 got.holdoff_active);
          n_errors++;
        end
        if (got.heat_permitted !== want.heat_permitted) begin
          $error("heat_permitted: expected %0b, got %0b", want.heat_permitted,
                 got.heat_permitted);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_beat_t b;
    int       walk;
    int       r;
    logic [LevelW-1:0] room;
    logic [1:0] phase_alt[7];
    bit         phase_en[7];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    n_errors = 0;
    n_cmds_checked = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    wait_cnt = WaitW'(StartupTicks);
    hold_cnt = '0;
    last_level = LevelLow;
    heating = 1'b0;
    cfg_en = 1'b1;
    cfg_alt = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(RegHeatingEnable, 2'd1);
    write_reg(RegAltitudeLevel, 2'd0);

    // start-up wait holds the heater off for the first four ticks
    add_row(ok_beat(600), 1, cmd(0, 0, 0));
    add_row(ok_beat(600), 1, cmd(0, 0, 0));
    b = ok_beat(600); b.lock_all = 1'b1;
    add_row(b, 1, cmd(0, 0, 0));
    add_row(ok_beat(600), 1, cmd(0, 0, 0));
    add_row(ok_beat(600), 1, cmd(1, 0, 1));
    add_row(ok_beat(-2048), 1, cmd(1, 0, 1));
    add_row(ok_beat(2047), 1, cmd(0, 0, 1));
    add_row(ok_beat(880), 0, cmd(0, 0, 0));
    add_row(ok_beat(929), 0, cmd(0, 0, 0));
    add_row(ok_beat(930), 0, cmd(0, 0, 0));
    add_row(ok_beat(881), 0, cmd(0, 0, 0));
    add_row(ok_beat(-500), 0, cmd(0, 0, 0));
    add_row(ok_beat(1500), 1, cmd(0, 0, 1));
    b = ok_beat(600); b.hot_tank_full = 1'b0;
    add_row(b, 1, cmd(0, 0, 0));
    b = ok_beat(600); b.lock_all = 1'b1;
    add_row(b, 1, cmd(0, 0, 0));
    b = ok_beat(600); b.hot_fault = 1'b1;
    add_row(b, 1, cmd(0, 0, 0));
    b = ok_beat(600); b.sterilizing = 1'b1;
    add_row(b, 1, cmd(0, 0, 0));
    b = ok_beat(600); b.cleaning_active = 1'b1;
    add_row(b, 1, cmd(0, 0, 0));
    b = ok_beat(600); b.unused_saving = 1'b1;
    add_row(b, 0, cmd(0, 0, 0));
    b = ok_beat(850); b.unused_saving = 1'b1;
    add_row(b, 0, cmd(0, 0, 0));
    b = ok_beat(800); b.sleep_saving = 1'b1;
    add_row(b, 0, cmd(0, 0, 0));
    b = ok_beat(849); b.unused_saving = 1'b1; b.sleep_saving = 1'b1;
    add_row(b, 0, cmd(0, 0, 0));
    b = ok_beat(600); b.room_level = 2'd2;
    add_row(b, 0, cmd(0, 0, 0));
    b = ok_beat(600); b.cover_open = 1'b1;
    add_row(b, 0, cmd(0, 0, 0));
    b = ok_beat(600); b.cover_open = 1'b1; b.room_level = 2'd3;
    add_row(b, 1, cmd(0, 1, 0));

    foreach (tick_rows[i]) send_tick(tick_rows[i].beat, tick_rows[i].typed, tick_rows[i].res);

    phase_en  = '{1, 1, 0, 1, 1, 0, 1};
    phase_alt = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd0, 2'd2, 2'd1};
    walk = 800;
    room = 2'd3;
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      write_reg(RegHeatingEnable, {1'b0, phase_en[ph]});
      write_reg(RegAltitudeLevel, phase_alt[ph]);
      no_idle = (ph == 2 || ph == 5);
      for (int i = 0; i < PhaseBeats; i++) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          if (walk < 550) walk += 25;
          else if (walk > 1000) walk -= 25;
          else walk += int'($urandom_range(0, 60)) - 30;
        end else if (r < 9) begin
          walk = int'($urandom_range(0, 2000)) - 500;
        end else begin
          walk = int'($urandom_range(0, 4095)) - 2048;
        end
        if ($urandom_range(0, 7) == 0) room = LevelW'($urandom_range(0, 3));
        b = ok_beat(walk);
        b.room_level = room;
        b.hot_tank_full = ($urandom_range(0, 9) != 0);
        b.cover_open = ($urandom_range(0, 29) == 0);
        b.lock_all = ($urandom_range(0, 24) == 0);
        b.hot_fault = ($urandom_range(0, 24) == 0);
        b.sterilizing = ($urandom_range(0, 24) == 0);
        b.cleaning_active = ($urandom_range(0, 24) == 0);
        b.unused_saving = ($urandom_range(0, 3) == 0);
        b.sleep_saving = ($urandom_range(0, 2) == 0);
        send_tick(b, 0, cmd(0, 0, 0));
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/whhc_pkg.sv
rtl/core/water_heater_hysteresis_control.sv
tb/water_heater_hysteresis_control_tb.sv
